### rtl/core/mlr_pkg.sv
// shared constants and types of the midpoint line rasterizer
`default_nettype none

package mlr_pkg;

  // coordinate width of every point and pixel
  localparam int COORD_BITS = 12;
  // signed decision variable, holds values between -2*major and 2*minor
  localparam int ERR_W = COORD_BITS + 2;
  // stream data widths, rounded up to whole bytes
  localparam int IN_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  // item kinds carried on in_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_W-1:0] err_t;

  // one input item after unpacking
  typedef struct packed {
    logic   mode;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } item_t;

  // status of the input register toward the pixel core
  typedef struct packed {
    logic valid;
  } stage_hs_t;

endpackage

`default_nettype wire

### rtl/core/mlr_in_reg.sv
// input register stage: unpacks and holds one item for the pixel core
`default_nettype none

module mlr_in_reg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // x_start, y_start, x_end, y_end from the lowest bit up, zero padded
  input  wire logic [mlr_pkg::IN_DATA_W-1:0] in_tdata,
  // mode
  input  wire logic                          in_tuser,
  input  wire logic                          item_take,
  output mlr_pkg::stage_hs_t                 hs,
  output mlr_pkg::item_t                     item
);

  localparam int CB = mlr_pkg::COORD_BITS;

  logic           valid_r;
  mlr_pkg::item_t item_r;
  mlr_pkg::item_t item_nxt;

  // free when empty or when the core takes the held item
  assign in_tready = !valid_r || item_take;

  // unpack the stream word
  always_comb begin
    item_nxt.mode    = in_tuser;
    item_nxt.x_start = in_tdata[CB-1:0];
    item_nxt.y_start = in_tdata[2*CB-1:CB];
    item_nxt.x_end   = in_tdata[3*CB-1:2*CB];
    item_nxt.y_end   = in_tdata[4*CB-1:3*CB];
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign hs.valid = valid_r;
  assign item     = item_r;

endmodule

`default_nettype wire

### rtl/core/mlr_core.sv
// line state, error term update and result register
`default_nettype none

module mlr_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mlr_pkg::stage_hs_t             hs,
  input  wire mlr_pkg::item_t                 item,
  output logic                                item_take,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [mlr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  localparam int CB = mlr_pkg::COORD_BITS;

  // line state
  mlr_pkg::coord_t cur_x_r, cur_x_nxt;
  mlr_pkg::coord_t cur_y_r, cur_y_nxt;
  mlr_pkg::err_t   err_r, err_nxt;
  mlr_pkg::coord_t delta_major_r, delta_major_nxt;
  mlr_pkg::coord_t delta_minor_r, delta_minor_nxt;
  mlr_pkg::coord_t steps_left_r, steps_left_nxt;
  logic            steep_r, steep_nxt;
  logic            active_r, active_nxt;

  // result register
  logic            out_valid_r;
  mlr_pkg::coord_t out_x_r;
  mlr_pkg::coord_t out_y_r;
  logic            out_last_r;

  // load arithmetic
  mlr_pkg::coord_t dx;
  mlr_pkg::coord_t dy;
  mlr_pkg::coord_t major_ld;
  mlr_pkg::coord_t minor_ld;
  mlr_pkg::err_t   err_ld;
  logic            steep_ld;
  logic            bad_ld;

  // step arithmetic
  mlr_pkg::err_t   err_adj;
  logic            err_pos;
  logic            is_last;

  logic            adv;
  logic            proc;
  logic            emit;

  // the result register frees up when empty or taken
  assign adv       = !out_valid_r || out_tready;
  assign item_take = adv;
  assign proc      = hs.valid && adv;
  assign emit      = proc && (item.mode == mlr_pkg::MODE_STEP) && active_r;

  // setup of a new line
  always_comb begin
    dx       = item.x_end - item.x_start;
    dy       = item.y_end - item.y_start;
    bad_ld   = (item.x_end < item.x_start) || (item.y_end < item.y_start) ||
               ((item.x_end == item.x_start) && (item.y_end == item.y_start));
    steep_ld = dy > dx;
    major_ld = steep_ld ? dy : dx;
    minor_ld = steep_ld ? dx : dy;
    err_ld   = {1'b0, minor_ld, 1'b0} - {2'b00, major_ld};
  end

  // one pixel step
  always_comb begin
    is_last = (steps_left_r == '0);
    err_pos = !err_r[mlr_pkg::ERR_W-1] && (err_r != '0);
    err_adj = err_pos ? (err_r - {1'b0, delta_major_r, 1'b0}) : err_r;
  end

  // next state
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    err_nxt         = err_r;
    delta_major_nxt = delta_major_r;
    delta_minor_nxt = delta_minor_r;
    steps_left_nxt  = steps_left_r;
    steep_nxt       = steep_r;
    active_nxt      = active_r;
    if (proc) begin
      if (item.mode == mlr_pkg::MODE_LOAD) begin
        if (bad_ld) begin
          active_nxt = 1'b0;
        end else begin
          cur_x_nxt       = item.x_start;
          cur_y_nxt       = item.y_start;
          err_nxt         = err_ld;
          delta_major_nxt = major_ld;
          delta_minor_nxt = minor_ld;
          steps_left_nxt  = major_ld;
          steep_nxt       = steep_ld;
          active_nxt      = 1'b1;
        end
      end else if (active_r) begin
        if (is_last) begin
          active_nxt = 1'b0;
        end else begin
          // minor axis moves when the error term is positive
          if (steep_r) begin
            cur_y_nxt = cur_y_r + 1'b1;
            cur_x_nxt = err_pos ? cur_x_r + 1'b1 : cur_x_r;
          end else begin
            cur_x_nxt = cur_x_r + 1'b1;
            cur_y_nxt = err_pos ? cur_y_r + 1'b1 : cur_y_r;
          end
          err_nxt        = err_adj + {1'b0, delta_minor_r, 1'b0};
          steps_left_nxt = steps_left_r - 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      err_r         <= '0;
      delta_major_r <= '0;
      delta_minor_r <= '0;
      steps_left_r  <= '0;
      steep_r       <= 1'b0;
      active_r      <= 1'b0;
    end else begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      err_r         <= err_nxt;
      delta_major_r <= delta_major_nxt;
      delta_minor_r <= delta_minor_nxt;
      steps_left_r  <= steps_left_nxt;
      steep_r       <= steep_nxt;
      active_r      <= active_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= cur_x_r;
      out_y_r    <= cur_y_r;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(mlr_pkg::OUT_DATA_W - 2 * CB){1'b0}}, out_y_r, out_x_r};

`ifndef SYNTHESIS
  // a load never produces a pixel
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && item.mode == mlr_pkg::MODE_LOAD) |=> !out_valid_r)
    else $error("load item produced a pixel");

  // the end pixel closes the line
  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> !active_r)
    else $error("line still active after its end pixel");

  // remaining steps never exceed the line length
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (steps_left_r <= delta_major_r))
    else $error("step count beyond line length");

  // decision variable stays at or below twice the minor delta
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ($signed(err_r) <= $signed({1'b0, delta_minor_r, 1'b0})))
    else $error("error term out of range");

  // a step on an idle block yields nothing
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && item.mode == mlr_pkg::MODE_STEP && !active_r) |=> !out_valid_r)
    else $error("pixel emitted while idle");
`endif

endmodule

`default_nettype wire

### rtl/core/midpoint_line_rasterizer_unit.sv
// top level of the midpoint line rasterizer
//
// Draws lines of non-negative slope one pixel per item with an integer error
// term. The input stream carries two kinds of item, chosen by in_tuser: a
// load (0) takes start and end points from in_tdata and sets up the line
// without a result; a step (1) returns the next pixel on the output stream,
// with out_tlast high on the end point, after which the block is idle.
// Steps while idle, and loads of unsupported lines (end left of or below
// start, or end equal to start), give no result.
// An accepted item is held in the input register and its pixel in the result
// register before it shows on out_tvalid. Throughput: one item per cycle
// unless the result register stalls; the error term update is a compare, a
// subtract and an add per pixel, held in the line state registers.
// Reset (rst_n low, synchronous) empties both registers and leaves the block
// idle with no line loaded. When the receiver holds out_tready low the result
// register keeps its pixel, one more item waits in the input register, and
// in_tready then drops until the pixel is taken.
`default_nettype none

module midpoint_line_rasterizer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // x_start, y_start, x_end, y_end from the lowest bit up, zero padded
  input  wire logic [mlr_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // pixel_x, pixel_y from the lowest bit up, zero padded
  output logic [mlr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  mlr_pkg::stage_hs_t hs;
  mlr_pkg::item_t     item;
  logic               item_take;

  // input register
  mlr_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .item_take (item_take),
    .hs        (hs),
    .item      (item)
  );

  // pixel core and result register
  mlr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .hs         (hs),
    .item       (item),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
